// ===== rtl/lrns_pkg.sv =====
// Package for the log ring newest-record scan block.
// Holds the sizes, CRC-16/Modbus constants, sequencer types and the byte CRC function.
// Depends on nothing; used by lrns_crc_unit and log_ring_newest_record_scan_unit.
`default_nettype none

package lrns_pkg;

	localparam int MAX_SLOTS  = 512;
	localparam int SLOT_W     = $clog2(MAX_SLOTS);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int MOD_W      = 2 * CNT_W - 1;
	localparam int REC_BYTES  = 28;
	localparam int REC_W      = 8 * REC_BYTES;
	localparam int BYTE_CNT_W = $clog2(REC_BYTES);
	localparam int MOD_CNT_W  = $clog2(CNT_W);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] SEQ_HALF = 16'h8000;

	localparam logic [CNT_W-1:0] SLOTS_RESET = CNT_W'(128);

	typedef enum logic {
		CFG_MAGIC = 1'b0,
		CFG_SLOTS = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CRC,
		ST_CHECK,
		ST_MOD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic init;
		logic en;
	} crc_ctl_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lrns_crc_unit.sv =====
// Byte-serial CRC-16/Modbus accumulator for the newest-record scan.
// Depends on lrns_pkg for the byte update function and the control struct.
`default_nettype none

module lrns_crc_unit import lrns_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire crc_ctl_t ctl,
	input  wire logic [7:0] data_byte,
	output logic [15:0]   crc
);

	logic [15:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.init) begin
			crc_q <= CRC_INIT;
		end else if (ctl.en) begin
			crc_q <= crc_byte(crc_q, data_byte);
		end
	end

	assign crc = crc_q;

endmodule

`default_nettype wire

// ===== rtl/log_ring_newest_record_scan_unit.sv =====
// Top level of the log ring newest-record scan block.
// Depends on lrns_pkg and instantiates lrns_crc_unit.
// Holds the configuration registers, the scan sequencer and the result registers.
`default_nettype none

// One record is taken per transfer on start while busy is low, in slot order.
// The CRC unit then folds in its bytes one at a time, and a check state makes
// the magic, CRC and sequence checks; a new record is taken only once busy is
// low again. The record in the last slot adds a remainder state, in which a
// one-bit-per-cycle remainder step forms the next write slot, and an emit
// state, after which the result appears on found, newest_seq, newest_slot and
// next_slot with done high for exactly one cycle. The receiver cannot stall,
// so the result must be captured in that cycle. Configuration writes take
// effect at once and should be made only while busy is low.
module log_ring_newest_record_scan_unit import lrns_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] stored_magic,
	input  wire logic [15:0] record_kind,
	input  wire logic [15:0] record_seq,
	input  wire logic [15:0] stored_crc,
	input  wire logic [31:0] data_word_0,
	input  wire logic [31:0] data_word_1,
	input  wire logic [31:0] data_word_2,
	input  wire logic [31:0] data_word_3,
	input  wire logic [31:0] data_word_4,
	input  wire logic [31:0] data_word_5,
	output logic             done,
	output logic             found,
	output logic [15:0]      newest_seq,
	output logic [SLOT_W-1:0] newest_slot,
	output logic [SLOT_W-1:0] next_slot
);

	localparam logic [BYTE_CNT_W-1:0] LAST_BYTE = BYTE_CNT_W'(REC_BYTES - 1);
	localparam logic [MOD_CNT_W-1:0]  MOD_TOP   = MOD_CNT_W'(CNT_W - 1);

	state_t state_q, state_d;

	logic [15:0]           record_magic_q;
	logic [CNT_W-1:0]      ring_slots_q;
	logic [REC_W-1:0]      rec_q;
	logic [15:0]           magic_q;
	logic [15:0]           scrc_q;
	logic [15:0]           seq_q;
	logic [BYTE_CNT_W-1:0] byte_cnt_q;
	logic [MOD_CNT_W-1:0]  mod_cnt_q;
	logic [CNT_W-1:0]      rem_q;
	logic [SLOT_W-1:0]     slot_cnt_q;
	logic                  have_best_q;
	logic [15:0]           best_seq_q;
	logic [SLOT_W-1:0]     best_slot_q;
	logic                  done_q;
	logic                  found_q;
	logic [15:0]           newest_seq_q;
	logic [SLOT_W-1:0]     newest_slot_q;
	logic [SLOT_W-1:0]     next_slot_q;

	crc_ctl_t          crc_ctl;
	logic [15:0]       crc_val;
	logic              accept;
	logic [CNT_W-1:0]  slot_n;
	logic [15:0]       seq_diff;
	logic              rec_ok;
	logic              take_rec;
	logic              new_have;
	logic [15:0]       new_seq;
	logic [SLOT_W-1:0] new_slot;
	logic              last_slot;
	logic [MOD_W-1:0]  div_shift;
	logic [CNT_W-1:0]  rem_next;

	lrns_crc_unit u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (crc_ctl),
		.data_byte (rec_q[7:0]),
		.crc       (crc_val)
	);

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		if (ring_slots_q == '0) begin
			slot_n = CNT_W'(1);
		end else if (ring_slots_q > CNT_W'(MAX_SLOTS)) begin
			slot_n = CNT_W'(MAX_SLOTS);
		end else begin
			slot_n = ring_slots_q;
		end
	end

	assign seq_diff  = seq_q - best_seq_q;
	assign rec_ok    = (magic_q == record_magic_q) && (crc_val == scrc_q);
	assign take_rec  = rec_ok && (!have_best_q || ((seq_diff != '0) && (seq_diff < SEQ_HALF)));
	assign new_have  = have_best_q || rec_ok;
	assign new_seq   = take_rec ? seq_q : best_seq_q;
	assign new_slot  = take_rec ? slot_cnt_q : best_slot_q;
	assign last_slot = ({1'b0, slot_cnt_q} + CNT_W'(1)) >= slot_n;

	assign div_shift = MOD_W'(slot_n) << mod_cnt_q;
	assign rem_next  = (MOD_W'(rem_q) >= div_shift) ? (rem_q - div_shift[CNT_W-1:0]) : rem_q;

	always_comb begin
		state_d      = state_q;
		crc_ctl.init = 1'b0;
		crc_ctl.en   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					crc_ctl.init = 1'b1;
					state_d      = ST_CRC;
				end
			end
			ST_CRC: begin
				crc_ctl.en = 1'b1;
				if (byte_cnt_q == LAST_BYTE) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = last_slot ? ST_MOD : ST_IDLE;
			end
			ST_MOD: begin
				if (mod_cnt_q == '0) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_magic_q <= '0;
			ring_slots_q   <= SLOTS_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MAGIC: record_magic_q <= cfg_data;
				CFG_SLOTS: ring_slots_q   <= cfg_data[CNT_W-1:0];
				default:   record_magic_q <= record_magic_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_q   <= {data_word_5, data_word_4, data_word_3, data_word_2,
				data_word_1, data_word_0, record_seq, record_kind};
			magic_q <= stored_magic;
			scrc_q  <= stored_crc;
			seq_q   <= record_seq;
		end else if (state_q == ST_CRC) begin
			rec_q <= rec_q >> 8;
		end
		if (state_q == ST_CHECK) begin
			rem_q <= {1'b0, new_slot} + CNT_W'(1);
		end else if (state_q == ST_MOD) begin
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q  <= '0;
			mod_cnt_q   <= '0;
			slot_cnt_q  <= '0;
			have_best_q <= 1'b0;
			best_seq_q  <= '0;
			best_slot_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					byte_cnt_q <= '0;
				end
				ST_CRC: begin
					byte_cnt_q <= byte_cnt_q + BYTE_CNT_W'(1);
				end
				ST_CHECK: begin
					have_best_q <= new_have;
					best_seq_q  <= new_seq;
					best_slot_q <= new_slot;
					mod_cnt_q   <= MOD_TOP;
					if (!last_slot) begin
						slot_cnt_q <= slot_cnt_q + SLOT_W'(1);
					end
				end
				ST_MOD: begin
					mod_cnt_q <= mod_cnt_q - MOD_CNT_W'(1);
				end
				ST_EMIT: begin
					slot_cnt_q  <= '0;
					have_best_q <= 1'b0;
					best_seq_q  <= '0;
					best_slot_q <= '0;
				end
				default: begin
					byte_cnt_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			found_q       <= have_best_q;
			newest_seq_q  <= have_best_q ? best_seq_q : '0;
			newest_slot_q <= have_best_q ? best_slot_q : '0;
			next_slot_q   <= have_best_q ? rem_q[SLOT_W-1:0] : '0;
		end
	end

	assign done        = done_q;
	assign found       = found_q;
	assign newest_seq  = newest_seq_q;
	assign newest_slot = newest_slot_q;
	assign next_slot   = next_slot_q;

	a_done_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_EMIT))
		else $error("result strobe without a preceding emit cycle");

	a_accept_starts_crc: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CRC) && (byte_cnt_q == '0))
		else $error("accepted record did not start the CRC pass");

	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result shown while the block is still busy");

	a_empty_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !found_q) |-> (newest_seq_q == '0) && (newest_slot_q == '0)
			&& (next_slot_q == '0))
		else $error("result without a valid record is not all zero");

	a_remainder_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (rem_q < slot_n))
		else $error("next slot remainder not fully reduced");

endmodule

`default_nettype wire
